@@ sv/m3i_pkg.sv @@
// Package for the 3x3 matrix inverse block.
// Holds the element counts and the bit positions of the result flags.
// No dependencies.
package m3i_pkg;

    localparam int N_DIM     = 3;
    localparam int N_ELEM    = 9;
    localparam int N_OUT_NUM = 10;

    // result flag positions in m_axis_tuser
    localparam int USER_SING = 0;
    localparam int USER_OVF  = 1;
    localparam int USER_BITS = 2;

endpackage

@@ sv/matrix3_inverse.sv @@
// Stages in order: products, cofactors, expansion, determinant sum, divider setup, divider, output register.
// Throughput: one matrix per cycle; the divider is unrolled, one quotient bit
// per stage for all nine elements, so every stage takes a new matrix each cycle.
// The pipeline holds only when the output register is full and not taken.
// Reset (i_rst_n low, synchronous) clears all stage valid bits; data is not reset.
// Inverse and determinant of a 3x3 signed fixed-point matrix via the adjugate.
// Depends on m3i_pkg.
module matrix3_inverse #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // in_r0c0, in_r0c1, in_r0c2, in_r1c0, ... in_r2c2 (lowest bits first)
    input  logic [((m3i_pkg::N_ELEM*WORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // inv_r0c0 .. inv_r2c2, determinant (lowest bits first)
    output logic [((m3i_pkg::N_OUT_NUM*WORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // singular, overflow
    output logic [m3i_pkg::USER_BITS-1:0] m_axis_tuser
);
    import m3i_pkg::*;

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int PW   = 2*W;
    localparam int CW   = 2*W + 1;
    localparam int DW   = 3*W + 3;
    localparam int NB   = CW + 2*F;
    localparam int CMPW = ((NB > DW) ? NB : DW) + 1;
    localparam int NST  = W + 6;
    localparam int OTDW = ((N_OUT_NUM*W+7)/8)*8;

    localparam logic [DW:0] D_LIM_POS = ({{DW{1'b0}}, 1'b1} << (W-1)) - {{DW{1'b0}}, 1'b1};
    localparam logic [DW:0] D_LIM_NEG = {{DW{1'b0}}, 1'b1} << (W-1);
    localparam logic [DW:0] D_HALF    = {{DW{1'b0}}, 1'b1} << (2*F-1);
    localparam logic [W:0]  Q_LIM_POS = ({{W{1'b0}}, 1'b1} << (W-1)) - {{W{1'b0}}, 1'b1};
    localparam logic [W:0]  Q_LIM_NEG = {{W{1'b0}}, 1'b1} << (W-1);
    localparam logic [W-1:0] V_MAX    = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] V_MIN    = {1'b1, {(W-1){1'b0}}};

    // global advance: the final register is empty or being taken
    logic w_en;
    logic [NST:1] r_vld;

    assign w_en          = !r_vld[NST] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[NST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-1:1], s_axis_tvalid};
        end
    end

    // unpack elements
    logic signed [W-1:0] w_a [0:N_ELEM-1];
    for (genvar k = 0; k < N_ELEM; k++) begin : g_unpack
        assign w_a[k] = s_axis_tdata[k*W +: W];
    end

    // stage 1: the eighteen cofactor products
    logic signed [PW-1:0] r_pa [0:N_ELEM-1];
    logic signed [PW-1:0] r_pb [0:N_ELEM-1];
    logic signed [W-1:0]  r_a1 [0:N_DIM-1];
    for (genvar i = 0; i < N_DIM; i++) begin : g_row
        for (genvar j = 0; j < N_DIM; j++) begin : g_col
            localparam int I1 = (i+1) % N_DIM;
            localparam int I2 = (i+2) % N_DIM;
            localparam int J1 = (j+1) % N_DIM;
            localparam int J2 = (j+2) % N_DIM;
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_pa[i*N_DIM+j] <= PW'(w_a[I1*N_DIM+J1]) * PW'(w_a[I2*N_DIM+J2]);
                    r_pb[i*N_DIM+j] <= PW'(w_a[I1*N_DIM+J2]) * PW'(w_a[I2*N_DIM+J1]);
                end
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < N_DIM; j++) r_a1[j] <= w_a[j];
        end
    end

    // stage 2: cofactors
    logic signed [CW-1:0] r_cof2 [0:N_ELEM-1];
    logic signed [W-1:0]  r_a2   [0:N_DIM-1];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < N_ELEM; k++) r_cof2[k] <= CW'(r_pa[k]) - CW'(r_pb[k]);
            for (int j = 0; j < N_DIM; j++) r_a2[j] <= r_a1[j];
        end
    end

    // stage 3: row-0 expansion as partial products (low and high cofactor halves)
    logic signed [CW-1:0] r_plo  [0:N_DIM-1];
    logic signed [CW-1:0] r_phi  [0:N_DIM-1];
    logic signed [CW-1:0] r_cof3 [0:N_ELEM-1];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < N_DIM; j++) begin
                r_plo[j] <= CW'(r_a2[j]) * CW'($signed({1'b0, r_cof2[j][W-1:0]}));
                r_phi[j] <= CW'(r_a2[j]) * CW'($signed(r_cof2[j][CW-1:W]));
            end
            for (int k = 0; k < N_ELEM; k++) r_cof3[k] <= r_cof2[k];
        end
    end

    // stage 4: determinant sum
    logic signed [DW-1:0] n_det4;
    logic signed [DW-1:0] r_det4;
    logic signed [CW-1:0] r_cof4 [0:N_ELEM-1];
    always_comb begin
        n_det4 = '0;
        for (int j = 0; j < N_DIM; j++) begin
            n_det4 = n_det4 + (DW'(r_phi[j]) <<< W) + DW'(r_plo[j]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_det4 <= n_det4;
            for (int k = 0; k < N_ELEM; k++) r_cof4[k] <= r_cof3[k];
        end
    end

    // divider pipeline registers; index 0 is the setup stage
    logic [DW-1:0] r_rem [0:W][0:N_ELEM-1];
    logic [W-1:0]  r_q   [0:W][0:N_ELEM-1];
    logic [W-1:0]  r_lo  [0:W][0:N_ELEM-1];
    logic          r_sat [0:W][0:N_ELEM-1];
    logic          r_sgn [0:W][0:N_ELEM-1];
    logic [DW-1:0] r_dmag [0:W];
    logic [W-1:0]  r_dres [0:W];
    logic          r_dovf [0:W];
    logic          r_sing [0:W];

    // stage 5: magnitudes, early saturation, determinant rounding
    logic [DW-1:0]  n_dmag;
    logic           n_dneg;
    logic [DW:0]    n_dq;
    logic           n_dsat;
    logic [W-1:0]   n_dres;
    logic [DW-1:0]  n_rem0 [0:N_ELEM-1];
    logic [W-1:0]   n_lo0  [0:N_ELEM-1];
    logic           n_sat0 [0:N_ELEM-1];
    logic           n_sgn0 [0:N_ELEM-1];
    logic signed [NB-1:0] n_num;
    logic [NB-1:0]  n_nmag;
    logic [CMPW-1:0] n_nhi;
    always_comb begin
        n_dneg = r_det4[DW-1];
        n_dmag = n_dneg ? DW'(-r_det4) : DW'(r_det4);
        n_dq   = ({1'b0, n_dmag} + D_HALF) >> (2*F);
        n_dsat = n_dneg ? (n_dq > D_LIM_NEG) : (n_dq > D_LIM_POS);
        if (n_dsat) begin
            n_dres = n_dneg ? V_MIN : V_MAX;
        end else begin
            n_dres = n_dneg ? W'(-n_dq) : W'(n_dq);
        end
        n_num  = '0;
        n_nmag = '0;
        n_nhi  = '0;
        for (int i = 0; i < N_DIM; i++) begin
            for (int j = 0; j < N_DIM; j++) begin
                // adjugate: inverse (i,j) takes cofactor (j,i)
                n_num  = NB'(r_cof4[j*N_DIM+i]) <<< (2*F);
                n_nmag = n_num[NB-1] ? NB'(-n_num) : NB'(n_num);
                n_nhi  = CMPW'(n_nmag >> W);
                n_sat0[i*N_DIM+j] = n_nhi >= CMPW'(n_dmag);
                n_rem0[i*N_DIM+j] = n_nhi[DW-1:0];
                n_lo0[i*N_DIM+j]  = n_nmag[W-1:0];
                n_sgn0[i*N_DIM+j] = n_num[NB-1] ^ n_dneg;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < N_ELEM; k++) begin
                r_rem[0][k] <= n_rem0[k];
                r_q[0][k]   <= '0;
                r_lo[0][k]  <= n_lo0[k];
                r_sat[0][k] <= n_sat0[k];
                r_sgn[0][k] <= n_sgn0[k];
            end
            r_dmag[0] <= n_dmag;
            r_dres[0] <= n_dres;
            r_dovf[0] <= n_dsat;
            r_sing[0] <= (n_dmag == '0);
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar s = 1; s <= W; s++) begin : g_div
        logic [DW:0]   w_r2 [0:N_ELEM-1];
        logic          w_ge [0:N_ELEM-1];
        logic [DW:0]   w_diff [0:N_ELEM-1];
        always_comb begin
            for (int k = 0; k < N_ELEM; k++) begin
                w_r2[k]   = {r_rem[s-1][k], r_lo[s-1][k][W-1]};
                w_ge[k]   = w_r2[k] >= {1'b0, r_dmag[s-1]};
                w_diff[k] = w_r2[k] - {1'b0, r_dmag[s-1]};
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                for (int k = 0; k < N_ELEM; k++) begin
                    r_rem[s][k] <= w_ge[k] ? w_diff[k][DW-1:0] : w_r2[k][DW-1:0];
                    r_q[s][k]   <= {r_q[s-1][k][W-2:0], w_ge[k]};
                    r_lo[s][k]  <= r_lo[s-1][k] << 1;
                    r_sat[s][k] <= r_sat[s-1][k];
                    r_sgn[s][k] <= r_sgn[s-1][k];
                end
                r_dmag[s] <= r_dmag[s-1];
                r_dres[s] <= r_dres[s-1];
                r_dovf[s] <= r_dovf[s-1];
                r_sing[s] <= r_sing[s-1];
            end
        end
    end

    // final stage: round, saturate, pack into the output register
    logic [W:0]      n_qr [0:N_ELEM-1];
    logic            n_eovf [0:N_ELEM-1];
    logic [OTDW-1:0] n_odata;
    logic            n_ovf;
    logic [OTDW-1:0] r_odata;
    logic [USER_BITS-1:0] r_ouser;
    always_comb begin
        n_odata = '0;
        n_ovf   = r_dovf[W];
        for (int k = 0; k < N_ELEM; k++) begin
            n_qr[k] = {1'b0, r_q[W][k]} +
                      (W+1)'({r_rem[W][k], 1'b0} >= {1'b0, r_dmag[W]});
            n_eovf[k] = r_sat[W][k] ||
                        (r_sgn[W][k] ? (n_qr[k] > Q_LIM_NEG) : (n_qr[k] > Q_LIM_POS));
            if (n_eovf[k]) begin
                n_odata[k*W +: W] = r_sgn[W][k] ? V_MIN : V_MAX;
            end else begin
                n_odata[k*W +: W] = r_sgn[W][k] ? W'(-n_qr[k]) : W'(n_qr[k]);
            end
            n_ovf = n_ovf | n_eovf[k];
        end
        n_odata[N_ELEM*W +: W] = r_dres[W];
        if (r_sing[W]) begin
            n_odata = '0;
            n_ovf   = 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_odata            <= n_odata;
            r_ouser[USER_SING] <= r_sing[W];
            r_ouser[USER_OVF]  <= n_ovf;
        end
    end

    assign m_axis_tdata = r_odata;
    assign m_axis_tuser = r_ouser;

    // a singular result carries all-zero numbers and no overflow
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[USER_SING] |->
            (m_axis_tdata == '0) && !m_axis_tuser[USER_OVF])
        else $error("singular result with nonzero data or overflow");

    // input is held off only while a result waits at the output
    a_ready_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // an accepted matrix is registered as valid in the first stage
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && w_en |=> r_vld[1])
        else $error("accepted transaction lost at pipeline entry");

endmodule

@@ sim/tb_matrix3_inverse.sv @@
// Self-checking testbench for the 3x3 fixed-point matrix inverse block.
// Predicts the adjugate inverse and determinant, checks every result in order.
// Depends on m3i_pkg and matrix3_inverse.
`timescale 1ns / 1ps

module tb_matrix3_inverse;
    import m3i_pkg::*;

    localparam int WB = 32;
    localparam int FB = 16;
    localparam int IN_W  = ((N_ELEM * WB + 7) / 8) * 8;
    localparam int OUT_W = ((N_OUT_NUM * WB + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = WB + 20;

    typedef logic signed [159:0] wide_t;
    typedef logic [N_ELEM-1:0][WB-1:0] matrix_t;

    typedef struct {
        logic [N_OUT_NUM-1:0][WB-1:0] nums;  // inverse row-major, then determinant
        logic                         sing;
        logic                         ovf;
    } inverse_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata = '0;   // in_r0c0 .. in_r2c2 (lowest bits first)
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;        // inv_r0c0 .. inv_r2c2, determinant
    logic [USER_BITS-1:0] m_axis_tuser;      // singular, overflow

    inverse_t expected_q[$];
    int       n_errors = 0;
    int       n_sent = 0;
    int       n_checked = 0;
    int       n_singular = 0;
    int       n_saturated = 0;
    int       send_gap_max = 3;   // 0 gives back-to-back stretches
    int       sink_stall_max = 3;

    matrix3_inverse #(.WORD_BITS(WB), .FRAC_BITS(FB)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Predictor: exact cofactors and determinant, rounded division
    // ---------------------------------------------------------------
    function automatic wide_t div_nearest(wide_t num, wide_t den);
        logic [159:0] an, ad, q, r;
        logic         flip;
        flip = num[159] ^ den[159];
        an = num[159] ? -num : num;
        ad = den[159] ? -den : den;
        q = an / ad;
        r = an % ad;
        if ((r << 1) >= ad) q = q + 1;   // ties go away from zero
        return flip ? -wide_t'(q) : wide_t'(q);
    endfunction

    function automatic logic [WB-1:0] clamp_word(wide_t v, inout logic ovf);
        wide_t hi, lo;
        hi = (wide_t'(1) <<< (WB - 1)) - 1;
        lo = -(wide_t'(1) <<< (WB - 1));
        if (v > hi) begin
            ovf = 1'b1;
            return hi[WB-1:0];
        end
        if (v < lo) begin
            ovf = 1'b1;
            return lo[WB-1:0];
        end
        return v[WB-1:0];
    endfunction

    function automatic inverse_t predict_inverse(matrix_t m);
        wide_t            a[3][3];
        wide_t            cof[3][3];
        wide_t            det;
        logic signed [WB-1:0] e;
        inverse_t         res;
        logic             ovf;
        ovf = 1'b0;
        det = '0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                e = m[i*3+j];
                a[i][j] = e;
            end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                cof[i][j] = a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3]
                          - a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3];
        for (int j = 0; j < 3; j++) det = det + a[0][j] * cof[0][j];
        res.nums = '0;
        res.ovf = 1'b0;
        res.sing = (det == 0);
        if (res.sing) return res;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                res.nums[i*3+j] = clamp_word(div_nearest(cof[j][i] <<< (2*FB), det), ovf);
        res.nums[9] = clamp_word(div_nearest(det, wide_t'(1) <<< (2*FB)), ovf);
        res.ovf = ovf;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Driver and checker
    // ---------------------------------------------------------------
    function automatic int pick_gap(int max_short);
        if (max_short == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
        return $urandom_range(0, max_short);
    endfunction

    task automatic send_matrix(matrix_t m);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= m;
        expected_q.push_back(predict_inverse(m));
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
        gap = pick_gap(send_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic report_mismatch(string what, logic [WB-1:0] got, logic [WB-1:0] exp);
        n_errors++;
        $display("[%0t] result %0d: %s got %h expected %h", $realtime, n_checked, what, got, exp);
    endtask

    // random output backpressure
    always @(posedge i_clk) begin
        if (sink_stall_max == 0)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= (pick_gap(sink_stall_max) == 0);
    end

    // compare each output transaction with the oldest prediction
    always @(posedge i_clk) begin
        inverse_t exp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result transaction", '0, '0);
            end else begin
                exp = expected_q.pop_front();
                for (int k = 0; k < N_OUT_NUM; k++)
                    if (m_axis_tdata[k*WB +: WB] !== exp.nums[k])
                        report_mismatch($sformatf("numeric field %0d", k),
                                        m_axis_tdata[k*WB +: WB], exp.nums[k]);
                if (m_axis_tuser[USER_SING] !== exp.sing)
                    report_mismatch("singular", m_axis_tuser[USER_SING], exp.sing);
                if (m_axis_tuser[USER_OVF] !== exp.ovf)
                    report_mismatch("overflow", m_axis_tuser[USER_OVF], exp.ovf);
                if (exp.sing) n_singular++;
                if (exp.ovf) n_saturated++;
            end
            n_checked++;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    function automatic logic [WB-1:0] q16(int whole);
        return WB'(whole) << FB;
    endfunction

    function automatic logic [WB-1:0] small_elem();
        // roughly +/-4.0 with a random fraction
        return WB'($signed($urandom_range(0, 1 << (FB + 3)))) - WB'(1 << (FB + 2));
    endfunction

    task automatic test_directed();
        matrix_t m;
        // identity
        m = '0;
        m[0] = q16(1); m[4] = q16(1); m[8] = q16(1);
        send_matrix(m);
        // all zero: singular
        send_matrix('0);
        // all extremes
        send_matrix({N_ELEM{32'h7fffffff}});
        send_matrix({N_ELEM{32'h80000000}});
        send_matrix({N_ELEM{32'hffffffff}});
        // diagonal of maximum and minimum: huge determinant saturates
        m = '0;
        m[0] = 32'h7fffffff; m[4] = 32'h80000000; m[8] = 32'h7fffffff;
        send_matrix(m);
        // tiny diagonal: inverse saturates
        m = '0;
        m[0] = 32'h1; m[4] = 32'h1; m[8] = 32'h1;
        send_matrix(m);
        m = '0;
        m[0] = 32'hffffffff; m[4] = 32'h1; m[8] = 32'h1;
        send_matrix(m);
        // diagonal 2,4,-8: exact reciprocals
        m = '0;
        m[0] = q16(2); m[4] = q16(4); m[8] = q16(-8);
        send_matrix(m);
        // diagonal 3,3,-3: rounding of 1/3
        m = '0;
        m[0] = q16(3); m[4] = q16(3); m[8] = q16(-3);
        send_matrix(m);
        // -32768 and two single-lsb entries on the diagonal: determinant is an exact negative half lsb tie
        m = '0;
        m[0] = 32'h80000000; m[4] = 32'h00000001; m[8] = 32'h00000001;
        send_matrix(m);
        // permutation and full non-diagonal matrix
        m = '0;
        m[1] = q16(1); m[5] = q16(1); m[6] = q16(-1);
        send_matrix(m);
        m = {q16(9), q16(8), q16(7), q16(6), q16(5), q16(4), q16(3), q16(2), q16(10)};
        send_matrix(m);
        // two equal rows: singular
        m = {q16(1), q16(2), q16(3), q16(1), q16(2), q16(3), q16(4), q16(5), q16(6)};
        send_matrix(m);
        // alternating bit patterns
        send_matrix({N_ELEM{32'h55555555}});
        send_matrix({N_ELEM{32'haaaaaaaa}});
        m = {32'h55555555, 32'haaaaaaaa, 32'h0, 32'h1, 32'h7fffffff,
             32'h80000000, 32'h12345678, 32'hfedcba98, 32'h00010000};
        send_matrix(m);
    endtask

    task automatic test_random_full(int count);
        matrix_t m;
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < N_ELEM; k++) m[k] = $urandom();
            send_matrix(m);
        end
    endtask

    task automatic test_random_conditioned(int count);
        matrix_t m;
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < N_ELEM; k++) m[k] = small_elem();
            send_matrix(m);
        end
    endtask

    task automatic test_random_singular(int count);
        matrix_t m;
        int      src, dst, scale;
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < N_ELEM; k++) m[k] = small_elem();
            src = $urandom_range(0, 2);
            dst = (src + $urandom_range(1, 2)) % 3;
            scale = $urandom_range(0, 4) - 2;
            // one row a whole multiple of another, or a zero column
            if ($urandom_range(0, 3) == 0)
                for (int r = 0; r < 3; r++) m[r*3 + src] = '0;
            else
                for (int c = 0; c < 3; c++) m[dst*3 + c] = m[src*3 + c] * WB'(scale);
            send_matrix(m);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_conditioned(500);
        test_random_full(350);
        test_random_singular(200);
        // back-to-back stretch with the sink always ready
        send_gap_max = 0;
        sink_stall_max = 0;
        test_random_conditioned(200);
        // back-to-back input against heavy stalls
        sink_stall_max = 6;
        test_random_full(180);
        send_gap_max = 3;
        sink_stall_max = 3;
        s_axis_tvalid <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d matrices, checked %0d results: %0d singular, %0d saturated.",
                 n_sent, n_checked, n_singular, n_saturated);
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout with %0d results outstanding", expected_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
